### rtl/assert_macros.svh
// Assertion macros used by lfb_skid, the output stage of the blend pipeline.
// Needs clk and arst_n in the scope of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LFB_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define LFB_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

### rtl/lfb_pkg.sv
// Shared types and constants of the linear feather blend pipeline.
// No dependencies; imported by every module of the block.
package lfb_pkg;

	localparam int MAX_WIDTH = 4096;
	localparam int COL_W     = 12;
	localparam int LW_W      = 13;
	localparam int CH_W      = 8;
	localparam int NUM_W     = 21;
	localparam int DIV_STEPS = CH_W;
	localparam int IDX_W     = 2;
	localparam int CFG_W     = LW_W;

	localparam logic [IDX_W-1:0] REG_BLEND_START = 2'd0;
	localparam logic [IDX_W-1:0] REG_LEFT_WIDTH  = 2'd1;
	localparam logic [IDX_W-1:0] REG_DARK_THRESH = 2'd2;

	localparam logic [COL_W-1:0] BLEND_START_RST = '0;
	localparam logic [LW_W-1:0]  LEFT_WIDTH_RST  = LW_W'(MAX_WIDTH);
	localparam logic [CH_W-1:0]  DARK_THRESH_RST = 8'd50;

	typedef struct packed {
		logic [COL_W-1:0] column;
		logic [CH_W-1:0]  left_blue;
		logic [CH_W-1:0]  left_green;
		logic [CH_W-1:0]  left_red;
		logic [CH_W-1:0]  warped_blue;
		logic [CH_W-1:0]  warped_green;
		logic [CH_W-1:0]  warped_red;
	} pix_in_t;

	typedef struct packed {
		logic [CH_W-1:0] out_blue;
		logic [CH_W-1:0] out_green;
		logic [CH_W-1:0] out_red;
	} pix_out_t;

	typedef struct packed {
		logic [COL_W-1:0] blend_start;
		logic [LW_W-1:0]  left_width;
		logic [CH_W-1:0]  dark_threshold;
	} cfg_t;

	// Weighted sums and their divisor, handed from the front end to the divider.
	typedef struct packed {
		logic [LW_W-1:0]  divisor;
		logic [NUM_W-1:0] num_blue;
		logic [NUM_W-1:0] num_green;
		logic [NUM_W-1:0] num_red;
	} mix_t;

endpackage

### rtl/lfb_front.sv
// Front end: region decode, weights, products and weighted sums (stages 1 to 4).
// Depends on lfb_pkg.
module lfb_front
	import lfb_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    adv,
	input  logic    in_valid,
	input  pix_in_t pix,
	input  cfg_t    cfg,
	output logic    mix_valid,
	output mix_t    mix
);

	localparam logic [1:0] MODE_LEFT = 2'd0;
	localparam logic [1:0] MODE_WARP = 2'd1;
	localparam logic [1:0] MODE_MIX  = 2'd2;

	logic             col_lt, col_ge, dark;
	logic [1:0]       mode;
	logic [LW_W-1:0]  span;
	logic [COL_W-1:0] offs;

	logic             v_s1, v_s2, v_s3, v_s4;
	logic [1:0]       mode_s1;
	logic [LW_W-1:0]  span_s1;
	logic [COL_W-1:0] offs_s1;
	pix_in_t          pix_s1, pix_s2;

	logic [LW_W-1:0]  wl, ww, sp;
	logic [LW_W-1:0]  wl_s2, ww_s2, sp_s2, sp_s3;

	logic [NUM_W-1:0] pl_b_s3, pl_g_s3, pl_r_s3;
	logic [NUM_W-1:0] pw_b_s3, pw_g_s3, pw_r_s3;
	mix_t             mix_s4;

	// Stage 1: decide the region, take span and offset.
	assign col_lt = pix.column < cfg.blend_start;
	assign col_ge = {1'b0, pix.column} >= cfg.left_width;
	assign dark   = (pix.warped_blue < cfg.dark_threshold)
		&& (pix.warped_green < cfg.dark_threshold)
		&& (pix.warped_red < cfg.dark_threshold);
	assign span   = cfg.left_width - {1'b0, cfg.blend_start};
	assign offs   = pix.column - cfg.blend_start;

	always_comb begin
		if (col_lt || (!col_ge && dark)) begin
			mode = MODE_LEFT;
		end else if (col_ge) begin
			mode = MODE_WARP;
		end else begin
			mode = MODE_MIX;
		end
	end

	// Stage 2: weights; pass-through regions use a unit divisor.
	always_comb begin
		case (mode_s1)
			MODE_WARP: begin
				wl = '0;
				ww = LW_W'(1);
				sp = LW_W'(1);
			end
			MODE_MIX: begin
				wl = span_s1 - {1'b0, offs_s1};
				ww = {1'b0, offs_s1};
				sp = span_s1;
			end
			default: begin
				wl = LW_W'(1);
				ww = '0;
				sp = LW_W'(1);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1 <= mode;
			span_s1 <= span;
			offs_s1 <= offs;
			pix_s1  <= pix;

			wl_s2  <= wl;
			ww_s2  <= ww;
			sp_s2  <= sp;
			pix_s2 <= pix_s1;

			// Stage 3: products.
			pl_b_s3 <= NUM_W'(pix_s2.left_blue) * NUM_W'(wl_s2);
			pl_g_s3 <= NUM_W'(pix_s2.left_green) * NUM_W'(wl_s2);
			pl_r_s3 <= NUM_W'(pix_s2.left_red) * NUM_W'(wl_s2);
			pw_b_s3 <= NUM_W'(pix_s2.warped_blue) * NUM_W'(ww_s2);
			pw_g_s3 <= NUM_W'(pix_s2.warped_green) * NUM_W'(ww_s2);
			pw_r_s3 <= NUM_W'(pix_s2.warped_red) * NUM_W'(ww_s2);
			sp_s3   <= sp_s2;

			// Stage 4: sums stay below 256 times the divisor.
			mix_s4.divisor   <= sp_s3;
			mix_s4.num_blue  <= pl_b_s3 + pw_b_s3;
			mix_s4.num_green <= pl_g_s3 + pw_g_s3;
			mix_s4.num_red   <= pl_r_s3 + pw_r_s3;
		end
	end

	assign mix_valid = v_s4;
	assign mix       = mix_s4;

endmodule

### rtl/lfb_div.sv
// Pipelined restoring divider: one quotient bit per stage, three channels.
// Depends on lfb_pkg.
module lfb_div
	import lfb_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     adv,
	input  logic     in_valid,
	input  mix_t     mix,
	output logic     out_valid,
	output pix_out_t res
);

	logic [DIV_STEPS-1:0] v_s;
	logic [LW_W-1:0]      sp_s   [DIV_STEPS];
	logic [NUM_W-1:0]     rem_s  [DIV_STEPS][3];
	logic [CH_W-1:0]      quo_s  [DIV_STEPS][3];

	logic [DIV_STEPS-1:0] v_in;
	logic [LW_W-1:0]      sp_in  [DIV_STEPS];
	logic [NUM_W-1:0]     rem_in [DIV_STEPS][3];
	logic [CH_W-1:0]      quo_in [DIV_STEPS][3];

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
		logic [NUM_W-1:0] dvs;

		if (j == 0) begin : g_first
			assign v_in[j]      = in_valid;
			assign sp_in[j]     = mix.divisor;
			assign rem_in[j][0] = mix.num_blue;
			assign rem_in[j][1] = mix.num_green;
			assign rem_in[j][2] = mix.num_red;
			assign quo_in[j][0] = '0;
			assign quo_in[j][1] = '0;
			assign quo_in[j][2] = '0;
		end else begin : g_next
			assign v_in[j]  = v_s[j-1];
			assign sp_in[j] = sp_s[j-1];
			for (genvar c = 0; c < 3; c++) begin : g_ch
				assign rem_in[j][c] = rem_s[j-1][c];
				assign quo_in[j][c] = quo_s[j-1][c];
			end
		end

		// Divisor aligned to the quotient bit of this stage.
		assign dvs = NUM_W'(sp_in[j]) << (DIV_STEPS - 1 - j);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (adv) begin
				v_s[j] <= v_in[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sp_s[j] <= sp_in[j];
				for (int c = 0; c < 3; c++) begin
					if (rem_in[j][c] >= dvs) begin
						rem_s[j][c] <= rem_in[j][c] - dvs;
						quo_s[j][c] <= {quo_in[j][c][CH_W-2:0], 1'b1};
					end else begin
						rem_s[j][c] <= rem_in[j][c];
						quo_s[j][c] <= {quo_in[j][c][CH_W-2:0], 1'b0};
					end
				end
			end
		end
	end

	assign out_valid     = v_s[DIV_STEPS-1];
	assign res.out_blue  = quo_s[DIV_STEPS-1][0];
	assign res.out_green = quo_s[DIV_STEPS-1][1];
	assign res.out_red   = quo_s[DIV_STEPS-1][2];

endmodule

### rtl/lfb_skid.sv
// Output register with one skid entry; decouples the pipeline from the receiver.
// Depends on lfb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lfb_skid
	import lfb_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  pix_out_t in_res,
	input  logic     dst_stall,
	output logic     adv,
	output logic     dst_valid,
	output pix_out_t dst_word
);

	logic     out_valid_q, skid_full_q;
	pix_out_t out_q, skid_q;
	logic     push, take;

	// Hold the whole pipeline only while the skid entry is occupied.
	assign adv  = !skid_full_q;
	assign push = in_valid && adv;
	assign take = out_valid_q && !dst_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (!out_valid_q || take) begin
			if (skid_full_q) begin
				out_valid_q <= 1'b1;
				skid_full_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || take) begin
			if (skid_full_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= in_res;
			end
		end else if (push) begin
			skid_q <= in_res;
		end
	end

	assign dst_valid = out_valid_q;
	assign dst_word  = out_q;

	`LFB_ASSERT_IMPL(a_skid_behind_out, skid_full_q, out_valid_q)
	`LFB_ASSERT_NEXT(a_skid_drains, skid_full_q && !dst_stall, !skid_full_q)
	`LFB_ASSERT_NEXT(a_skid_catches, push && out_valid_q && dst_stall, skid_full_q)

endmodule

### rtl/linear_feather_blend_top.sv
// Linear feather blend of a left and a warped BGR pixel stream, top level.
// Depends on lfb_pkg, lfb_front, lfb_div and lfb_skid.
//
// Usage:
// - src channel: one word per pixel (column, left BGR, warped BGR), taken at an
//   edge with src_valid high and src_stall low.
// - dst channel: one blended BGR word per accepted pixel, in order, taken at an
//   edge with dst_valid high and dst_stall low.
// - Write port: wr_en with wr_index selects blend_start, left_width or
//   dark_threshold; write only while no pixel is in flight.
// - Pipeline: from acceptance to dst_valid a word passes four front stages
//   (region decode, weights, multipliers, sums), eight divider stages that
//   each resolve one quotient bit, and the output register.
// - Throughput: one pixel per clock unless the skid is full; divider fully pipelined.
// - Stall: when dst stalls, the next finished word drops into a skid entry and
//   the whole pipeline holds; src_stall is the registered skid-full flag.
// - Reset: arst_n empties the pipeline and the output side and loads
//   blend_start 0, left_width 4096 and dark_threshold 50.
module linear_feather_blend_top
	import lfb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             src_valid,
	output logic             src_stall,
	input  pix_in_t          src_word,
	output logic             dst_valid,
	input  logic             dst_stall,
	output pix_out_t         dst_word,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0] wr_data
);

	cfg_t     cfg_q;
	logic     adv;
	logic     mix_valid;
	mix_t     mix;
	logic     res_valid;
	pix_out_t res;

	// Configuration registers; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blend_start    <= BLEND_START_RST;
			cfg_q.left_width     <= LEFT_WIDTH_RST;
			cfg_q.dark_threshold <= DARK_THRESH_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_BLEND_START: cfg_q.blend_start    <= wr_data[COL_W-1:0];
				REG_LEFT_WIDTH:  cfg_q.left_width     <= wr_data[LW_W-1:0];
				REG_DARK_THRESH: cfg_q.dark_threshold <= wr_data[CH_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Accept a word whenever the pipeline advances.
	assign src_stall = !adv;

	lfb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (src_valid),
		.pix       (src_word),
		.cfg       (cfg_q),
		.mix_valid (mix_valid),
		.mix       (mix)
	);

	lfb_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (mix_valid),
		.mix       (mix),
		.out_valid (res_valid),
		.res       (res)
	);

	lfb_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_res    (res),
		.dst_stall (dst_stall),
		.adv       (adv),
		.dst_valid (dst_valid),
		.dst_word  (dst_word)
	);

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for linear_feather_blend_top: directed corners, then random pixels.
// Depends on lfb_pkg and the blend RTL; a small scoreboard class predicts every word.

class blend_board;
	lfb_pkg::cfg_t cfg;
	lfb_pkg::pix_out_t pending[$];
	int errors;

	function new();
		cfg.blend_start = lfb_pkg::BLEND_START_RST;
		cfg.left_width = lfb_pkg::LEFT_WIDTH_RST;
		cfg.dark_threshold = lfb_pkg::DARK_THRESH_RST;
		errors = 0;
	endfunction

	function void set_config(lfb_pkg::cfg_t c);
		cfg = c;
	endfunction

	// Integer feather weight: floor((l*(W-d) + w*d) / W).
	function logic [lfb_pkg::CH_W-1:0] mix(int l, int w, int d, int span);
		return lfb_pkg::CH_W'((l * (span - d) + w * d) / span);
	endfunction

	function lfb_pkg::pix_out_t blend_pixel(lfb_pkg::pix_in_t p);
		lfb_pkg::pix_out_t r;
		int span;
		int d;
		if (p.column < cfg.blend_start) begin
			r = {p.left_blue, p.left_green, p.left_red};
		end else if ({1'b0, p.column} >= cfg.left_width) begin
			r = {p.warped_blue, p.warped_green, p.warped_red};
		end else if (p.warped_blue < cfg.dark_threshold && p.warped_green < cfg.dark_threshold
				&& p.warped_red < cfg.dark_threshold) begin
			// warped image is empty here: keep the left pixel
			r = {p.left_blue, p.left_green, p.left_red};
		end else begin
			span = int'(cfg.left_width) - int'(cfg.blend_start);
			d = int'(p.column) - int'(cfg.blend_start);
			r.out_blue = mix(p.left_blue, p.warped_blue, d, span);
			r.out_green = mix(p.left_green, p.warped_green, d, span);
			r.out_red = mix(p.left_red, p.warped_red, d, span);
		end
		return r;
	endfunction

	function void note_pixel(lfb_pkg::pix_in_t p);
		pending = {pending, blend_pixel(p)};
	endfunction

	function void check_pixel(lfb_pkg::pix_out_t got);
		lfb_pkg::pix_out_t want;
		if (pending.size() == 0) begin
			errors++;
			$display("%0t: word %h with nothing expected", $time, got);
			return;
		end
		want = pending.pop_front();
		if (got.out_blue != want.out_blue) begin
			errors++;
			$display("%0t: out_blue expected %0d got %0d", $time, want.out_blue, got.out_blue);
		end
		if (got.out_green != want.out_green) begin
			errors++;
			$display("%0t: out_green expected %0d got %0d", $time, want.out_green, got.out_green);
		end
		if (got.out_red != want.out_red) begin
			errors++;
			$display("%0t: out_red expected %0d got %0d", $time, want.out_red, got.out_red);
		end
	endfunction
endclass

module tb;
	import lfb_pkg::*;

	// drain margin for the pipeline registers and the skid entry
	localparam int DRAIN_CYCLES = 24;
	localparam int PHASES = 14;
	localparam int PHASE_ITEMS = 125;

	logic clk;
	logic arst_n = 1'b0;
	logic src_valid = 1'b0;
	logic src_stall;
	pix_in_t src_word = '0;
	logic dst_valid;
	logic dst_stall = 1'b0;
	pix_out_t dst_word;
	logic wr_en = 1'b0;
	logic [IDX_W-1:0] wr_index = REG_BLEND_START;
	logic [CFG_W-1:0] wr_data = '0;

	// gaps on both sides only while this is set
	bit idle_on = 1'b1;

	blend_board board = new();

	linear_feather_blend_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_word(src_word),
		.dst_valid(dst_valid),
		.dst_stall(dst_stall),
		.dst_word(dst_word),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watch both channels; sampled values are the ones from before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (src_valid && !src_stall)
				board.note_pixel(src_word);
			if (dst_valid && !dst_stall)
				board.check_pixel(dst_word);
		end
	end

	// Receiver: while idle_on is set, stall for a random draw (maybe none) before taking each word.
	initial begin
		int n;
		forever begin
			n = idle_on ? $urandom_range(0, 7) : 0;
			if (n > 0) begin
				dst_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			dst_stall <= 1'b0;
			@(posedge clk);
			while (!dst_valid) @(posedge clk);
		end
	end

	// Drive one input word after a random gap; return on the edge that takes it.
	task automatic push_pixel(input pix_in_t p);
		int gap;
		gap = idle_on ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		src_valid <= 1'b1;
		src_word <= p;
		@(posedge clk);
		while (src_stall) @(posedge clk);
	endtask

	// Hold off until every predicted word has come out, then let the pipe settle.
	task automatic wait_idle();
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_config(input cfg_t c);
		wr_en <= 1'b1;
		wr_index <= REG_BLEND_START;
		wr_data <= CFG_W'(c.blend_start);
		@(posedge clk);
		wr_index <= REG_LEFT_WIDTH;
		wr_data <= c.left_width;
		@(posedge clk);
		wr_index <= REG_DARK_THRESH;
		wr_data <= CFG_W'(c.dark_threshold);
		@(posedge clk);
		wr_en <= 1'b0;
		board.set_config(c);
	endtask

	function automatic pix_in_t make_pixel(int col, int lb, int lg, int lr,
			int wb, int wg, int wr);
		pix_in_t p;
		p.column = COL_W'(col);
		p.left_blue = CH_W'(lb);
		p.left_green = CH_W'(lg);
		p.left_red = CH_W'(lr);
		p.warped_blue = CH_W'(wb);
		p.warped_green = CH_W'(wg);
		p.warped_red = CH_W'(wr);
		return p;
	endfunction

	function automatic cfg_t make_config(int bs, int lw, int thr);
		cfg_t c;
		c.blend_start = COL_W'(bs);
		c.left_width = LW_W'(lw);
		c.dark_threshold = CH_W'(thr);
		return c;
	endfunction

	// Random setting: mostly narrow or wide overlaps, some empty ones and the extremes.
	function automatic cfg_t draw_config();
		int kind;
		int bs;
		int lw;
		int thr;
		kind = $urandom_range(0, 9);
		bs = $urandom_range(0, 4095);
		case (kind)
			0: lw = $urandom_range(0, bs);
			1: begin
				bs = $urandom_range(0, 1) ? 0 : 4095;
				lw = $urandom_range(0, 1) ? 8191 : 4096;
			end
			2, 3, 4: lw = bs + $urandom_range(1, 16);
			default: lw = bs + $urandom_range(1, 4096);
		endcase
		if (lw > 8191)
			lw = 8191;
		case ($urandom_range(0, 5))
			0: thr = 0;
			1: thr = 255;
			2: thr = 50;
			default: thr = $urandom_range(0, 255);
		endcase
		return make_config(bs, lw, thr);
	endfunction

	// Random pixel aimed mostly at the overlap and at the dark-pixel boundary.
	function automatic pix_in_t draw_pixel(cfg_t c);
		pix_in_t p;
		int lo;
		int hi;
		int thr;
		p = make_pixel(0, $urandom_range(0, 255), $urandom_range(0, 255),
			$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
			$urandom_range(0, 255));
		if ($urandom_range(0, 4) != 0) begin
			lo = (c.blend_start >= 8) ? int'(c.blend_start) - 8 : 0;
			hi = int'(c.left_width) + 8;
			if (hi > 4095)
				hi = 4095;
			if (hi < lo)
				hi = lo;
			p.column = COL_W'($urandom_range(lo, hi));
		end else begin
			p.column = COL_W'($urandom_range(0, 4095));
		end
		thr = c.dark_threshold;
		if (thr > 0) begin
			case ($urandom_range(0, 3))
				0: begin
					p.warped_blue = CH_W'($urandom_range(0, thr - 1));
					p.warped_green = CH_W'($urandom_range(0, thr - 1));
					p.warped_red = CH_W'($urandom_range(0, thr - 1));
				end
				1: begin
					// two channels dark, the third right on the threshold
					p.warped_blue = CH_W'(thr - 1);
					p.warped_green = CH_W'($urandom_range(0, thr - 1));
					p.warped_red = CH_W'(thr);
				end
				default: ;
			endcase
		end
		return p;
	endfunction

	initial begin
		cfg_t c;
		arst_n <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset setting: overlap spans the whole row, threshold 50.
		push_pixel(make_pixel(0, 0, 0, 0, 0, 0, 0));
		push_pixel(make_pixel(0, 255, 255, 255, 255, 255, 255));
		push_pixel(make_pixel(4095, 0, 0, 0, 255, 255, 255));
		push_pixel(make_pixel(2048, 255, 0, 128, 60, 200, 49));
		src_valid <= 1'b0;
		wait_idle();

		// Narrow overlap: both edges, just past it, dark and threshold-boundary pixels.
		load_config(make_config(100, 300, 50));
		push_pixel(make_pixel(99, 10, 20, 30, 200, 210, 220));
		push_pixel(make_pixel(100, 10, 20, 30, 200, 210, 220));
		push_pixel(make_pixel(299, 10, 20, 30, 200, 210, 220));
		push_pixel(make_pixel(300, 10, 20, 30, 200, 210, 220));
		push_pixel(make_pixel(200, 90, 91, 92, 49, 49, 49));
		push_pixel(make_pixel(200, 90, 91, 92, 49, 49, 50));
		push_pixel(make_pixel(150, 255, 255, 255, 0, 128, 255));
		src_valid <= 1'b0;
		wait_idle();

		// Empty overlap: left of blend_start gives left, the rest gives warped.
		load_config(make_config(500, 200, 0));
		push_pixel(make_pixel(499, 1, 2, 3, 4, 5, 6));
		push_pixel(make_pixel(500, 1, 2, 3, 4, 5, 6));
		push_pixel(make_pixel(4095, 1, 2, 3, 4, 5, 6));
		src_valid <= 1'b0;
		wait_idle();

		// Zero left_width: every column is warped, even dark ones.
		load_config(make_config(0, 0, 255));
		push_pixel(make_pixel(0, 7, 8, 9, 254, 254, 254));
		push_pixel(make_pixel(4095, 7, 8, 9, 0, 0, 0));
		src_valid <= 1'b0;
		wait_idle();

		// Largest registers: overlap starts at the last column.
		load_config(make_config(4095, 8191, 255));
		push_pixel(make_pixel(4095, 12, 34, 56, 255, 255, 255));
		push_pixel(make_pixel(4094, 12, 34, 56, 255, 255, 255));
		push_pixel(make_pixel(4095, 12, 34, 56, 254, 254, 254));
		src_valid <= 1'b0;
		wait_idle();

		// Widest overlap: full-scale weights on both sides.
		load_config(make_config(0, 8191, 0));
		push_pixel(make_pixel(4095, 255, 255, 255, 255, 255, 255));
		push_pixel(make_pixel(1, 255, 0, 255, 0, 255, 255));
		src_valid <= 1'b0;
		wait_idle();

		// Random phases, each under a fresh setting; every fourth runs with no gaps.
		for (int ph = 0; ph < PHASES; ph++) begin
			c = draw_config();
			load_config(c);
			idle_on = (ph % 4 != 1);
			for (int i = 0; i < PHASE_ITEMS; i++)
				push_pixel(draw_pixel(c));
			src_valid <= 1'b0;
			wait_idle();
		end
		idle_on = 1'b1;

		if (board.errors == 0)
			$display("linear_feather_blend_top: match");
		else
			$display("linear_feather_blend_top: mismatch");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#1000000;
		$display("linear_feather_blend_top: mismatch");
		$finish;
	end

endmodule
